### rtl/fbpa_pkg.sv
// Shared types, widths and codes of the fixed block pool allocator.
package fbpa_pkg;

  localparam int CNT_W      = 9;   // block count and free count
  localparam int IDX_OUT_W  = 8;   // block index on the stream ports
  localparam int ADDR_W     = 32;  // byte address and base address
  localparam int BSIZE_W    = 17;  // configured block size
  localparam int PSIZE_W    = 18;  // aligned block size
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;

  localparam logic [CNT_W-1:0]   MIN_BLOCKS = 9'd2;
  localparam logic [BSIZE_W-1:0] MIN_BSIZE  = 17'd4;

  typedef enum logic [1:0] {
    MODE_CREATE  = 2'd0,
    MODE_GET     = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_CREATED = 3'd1,
    ST_UNDERFLOW   = 3'd2,
    ST_OVERFLOW    = 3'd3,
    ST_BAD         = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_COUNT  = 2'd0,
    REG_BASE_ADDRESS = 2'd1,
    REG_BLOCK_SIZE   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    status_e               status;
    logic [IDX_OUT_W-1:0]  index;
    logic [ADDR_W-1:0]     addr;
    logic [CNT_W-1:0]      free;
  } resp_t;

endpackage

### rtl/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator: LIFO free list with sequencer and shared units.
//
// Requests enter on the s_axis channel, one per accepted beat (mode, block
// index). Each request gives exactly one response on m_axis: status, granted
// index, block address and the free count after the request. Configuration
// registers (block count, base address, block size) are written on the cfg
// channel, which is always ready; write them only while no request is open.
// Flow: release, a rejected request and a bad create go from accept to
// the response register via S_RESP; get passes S_GET first, since the link
// store read and the index times size product are both registered before
// the base add. Create lays out block_count entries, with block_count capped
// at MAX_BLOCKS: the align unit rounds the base and then the size (reciprocal
// multiply, remainder, pad add), S_ALIGN_SIZE starts the walk, the link store
// is written one entry per cycle, and S_RESP hands over.
// One request is in flight at a time; tready
// falls for its duration. The response sits in an output register, so the
// next request may be accepted while that response waits for m_axis_tready.
// Reset leaves the pool not created with a zero free count; the link store
// is not cleared, create lays it out. A stalled receiver holds the response
// and the block stops taking requests once a new response is ready.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS  = 256,
  parameter int ALIGN_BYTES = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // mode [1:0], block_index [9:2], zero fill
  input  logic [fbpa_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // status [2:0], granted_index [10:3], block_address [42:11],
  // free_count [51:43], zero fill
  output logic [fbpa_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CW    = fbpa_pkg::CNT_W;
  localparam int PAD_W = fbpa_pkg::OUT_TDATA_W - $bits(fbpa_pkg::resp_t);

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_ALIGN_BASE = 6'b000010,
    S_ALIGN_SIZE = 6'b000100,
    S_WALK       = 6'b001000,
    S_GET        = 6'b010000,
    S_RESP       = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]                    cfg_count_q;
  logic [fbpa_pkg::ADDR_W-1:0]      cfg_base_q;
  logic [fbpa_pkg::BSIZE_W-1:0]     cfg_size_q;

  logic                             created_q, created_d;
  logic [IDX_W-1:0]                 head_q, head_d;
  logic [CW-1:0]                    free_q, free_d;
  logic [CW-1:0]                    pool_count_q, pool_count_d;
  logic [fbpa_pkg::ADDR_W-1:0]      pool_base_q, pool_base_d;
  logic [fbpa_pkg::PSIZE_W-1:0]     pool_size_q, pool_size_d;
  logic [CW-1:0]                    walk_n_q, walk_n_d;
  logic [CW-1:0]                    walk_cnt_q, walk_cnt_d;
  logic [CW-1:0]                    walk_nxt;
  logic [CW-1:0]                    create_n;

  fbpa_pkg::resp_t                  res_q, res_d;
  logic                             out_valid_q, out_valid_d;
  fbpa_pkg::resp_t                  out_q, out_d;

  logic                             in_acc;
  fbpa_pkg::mode_e                  in_mode;
  logic [fbpa_pkg::IDX_OUT_W-1:0]   in_idx;

  logic                             ram_we, ram_re;
  logic [IDX_W-1:0]                 ram_waddr;
  logic [IDX_W-1:0]                 ram_wdata;
  logic [IDX_W-1:0]                 ram_rdata;

  logic                             align_start, align_done;
  logic [fbpa_pkg::ADDR_W-1:0]      align_operand, align_result;
  logic                             mul_en;
  logic [fbpa_pkg::ADDR_W-1:0]      blk_addr;

  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign in_mode       = fbpa_pkg::mode_e'(s_axis_tdata[1:0]);
  assign in_idx        = s_axis_tdata[9:2];
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {PAD_W'(0), out_q.free, out_q.addr, out_q.index, out_q.status};

  assign create_n = (32'(cfg_count_q) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : cfg_count_q;
  assign walk_nxt = walk_cnt_q + 1'b1;

  fbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  fbpa_align_unit #(
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_align (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (align_start),
    .operand_i (align_operand),
    .done_o    (align_done),
    .result_o  (align_result)
  );

  fbpa_addr_unit #(
    .IDX_W (IDX_W)
  ) u_addr (
    .clk_i   (clk_i),
    .en_i    (mul_en),
    .index_i (head_q),
    .size_i  (pool_size_q),
    .base_i  (pool_base_q),
    .addr_o  (blk_addr)
  );

  always_comb begin
    state_d       = state_q;
    created_d     = created_q;
    head_d        = head_q;
    free_d        = free_q;
    pool_count_d  = pool_count_q;
    pool_base_d   = pool_base_q;
    pool_size_d   = pool_size_q;
    walk_n_d      = walk_n_q;
    walk_cnt_d    = walk_cnt_q;
    res_d         = res_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    align_start   = 1'b0;
    align_operand = '0;
    mul_en        = 1'b0;
    out_valid_d   = out_valid_q;
    out_d         = out_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d   = '{fbpa_pkg::ST_OK, '0, '0, free_q};
          state_d = S_RESP;
          unique case (in_mode)
            fbpa_pkg::MODE_CREATE: begin
              if (cfg_count_q < fbpa_pkg::MIN_BLOCKS || cfg_size_q < fbpa_pkg::MIN_BSIZE) begin
                created_d    = 1'b0;
                free_d       = '0;
                pool_count_d = '0;
                head_d       = '0;
                res_d        = '{fbpa_pkg::ST_NOT_CREATED, '0, '0, '0};
              end else begin
                walk_n_d      = create_n;
                align_start   = 1'b1;
                align_operand = cfg_base_q;
                state_d       = S_ALIGN_BASE;
              end
            end
            fbpa_pkg::MODE_GET: begin
              if (!created_q) begin
                res_d.status = fbpa_pkg::ST_NOT_CREATED;
              end else if (free_q == '0) begin
                res_d.status = fbpa_pkg::ST_UNDERFLOW;
              end else begin
                ram_re  = 1'b1;
                mul_en  = 1'b1;
                state_d = S_GET;
              end
            end
            fbpa_pkg::MODE_RELEASE: begin
              if (!created_q) begin
                res_d.status = fbpa_pkg::ST_NOT_CREATED;
              end else if (CW'(in_idx) >= pool_count_q) begin
                res_d.status = fbpa_pkg::ST_BAD;
              end else if (free_q >= pool_count_q) begin
                res_d.status = fbpa_pkg::ST_OVERFLOW;
              end else begin
                // push: link the old head behind the released block
                ram_we     = 1'b1;
                ram_waddr  = IDX_W'(in_idx);
                ram_wdata  = head_q;
                head_d     = IDX_W'(in_idx);
                free_d     = free_q + 1'b1;
                res_d.free = free_q + 1'b1;
              end
            end
            default: begin
              res_d.status = fbpa_pkg::ST_BAD;
            end
          endcase
        end
      end
      S_ALIGN_BASE: begin
        if (align_done) begin
          pool_base_d   = align_result;
          align_start   = 1'b1;
          align_operand = fbpa_pkg::ADDR_W'(cfg_size_q);
          state_d       = S_ALIGN_SIZE;
        end
      end
      S_ALIGN_SIZE: begin
        if (align_done) begin
          pool_size_d = align_result[fbpa_pkg::PSIZE_W-1:0];
          walk_cnt_d  = '0;
          state_d     = S_WALK;
        end
      end
      S_WALK: begin
        ram_we     = 1'b1;
        ram_waddr  = IDX_W'(walk_cnt_q);
        ram_wdata  = (walk_nxt < walk_n_q) ? IDX_W'(walk_nxt) : '0;
        walk_cnt_d = walk_nxt;
        if (walk_nxt == walk_n_q) begin
          pool_count_d = walk_n_q;
          head_d       = '0;
          free_d       = walk_n_q;
          created_d    = 1'b1;
          res_d        = '{fbpa_pkg::ST_OK, '0, '0, walk_n_q};
          state_d      = S_RESP;
        end
      end
      S_GET: begin
        // pop: the link read of the old head becomes the new head
        head_d  = ram_rdata;
        free_d  = free_q - 1'b1;
        res_d   = '{fbpa_pkg::ST_OK, fbpa_pkg::IDX_OUT_W'(head_q), blk_addr, free_q - 1'b1};
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      created_q    <= 1'b0;
      head_q       <= '0;
      free_q       <= '0;
      pool_count_q <= '0;
      pool_base_q  <= '0;
      pool_size_q  <= '0;
      walk_n_q     <= '0;
      walk_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
      cfg_count_q  <= 9'd256;
      cfg_base_q   <= '0;
      cfg_size_q   <= 17'd4;
    end else begin
      state_q      <= state_d;
      created_q    <= created_d;
      head_q       <= head_d;
      free_q       <= free_d;
      pool_count_q <= pool_count_d;
      pool_base_q  <= pool_base_d;
      pool_size_q  <= pool_size_d;
      walk_n_q     <= walk_n_d;
      walk_cnt_q   <= walk_cnt_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (fbpa_pkg::cfg_reg_e'(cfg_index_i))
          fbpa_pkg::REG_BLOCK_COUNT:  cfg_count_q <= cfg_data_i[CW-1:0];
          fbpa_pkg::REG_BASE_ADDRESS: cfg_base_q  <= cfg_data_i;
          fbpa_pkg::REG_BLOCK_SIZE:   cfg_size_q  <= cfg_data_i[fbpa_pkg::BSIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule

### rtl/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/fbpa_align_unit.sv
// Align-up unit: rounds a 32-bit value up to the alignment with one shared reciprocal multiplier.
module fbpa_align_unit #(
  parameter int ALIGN_BYTES = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fbpa_pkg::ADDR_W-1:0] operand_i,
  output logic                        done_o,
  output logic [fbpa_pkg::ADDR_W-1:0] result_o
);

  localparam int AW     = fbpa_pkg::ADDR_W;
  localparam int SHIFT  = AW + $clog2(ALIGN_BYTES);
  localparam int PW     = $clog2(ALIGN_BYTES + 1);
  localparam int MB_W   = 17;
  localparam int PROD_W = AW + MB_W;
  localparam int SUM_W  = PROD_W + 16;
  // ceil(2^SHIFT / ALIGN_BYTES) gives the exact quotient for every 32-bit operand
  localparam logic [63:0]     RECIP    =
    ((64'd1 << SHIFT) + 64'(ALIGN_BYTES - 1)) / 64'(ALIGN_BYTES);
  localparam logic [MB_W-1:0] RECIP_LO = MB_W'(RECIP[15:0]);
  localparam logic [MB_W-1:0] RECIP_HI = RECIP[32:16];
  localparam logic [AW-1:0]   ALIGN_A  = AW'(ALIGN_BYTES);
  localparam logic [PW-1:0]   ALIGN_P  = PW'(ALIGN_BYTES);

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_LO   = 5'b00010,
    PH_HI   = 5'b00100,
    PH_REM  = 5'b01000,
    PH_ADD  = 5'b10000
  } phase_e;

  phase_e              phase_q, phase_d;
  logic                done_q, done_d;
  logic [AW-1:0]       op_q, op_d;
  logic [PROD_W-1:0]   acc_q, acc_d;
  logic [AW-1:0]       quot_q, quot_d;
  logic [PW-1:0]       rem_q, rem_d;
  logic [AW-1:0]       res_q, res_d;
  logic [MB_W-1:0]     mult_b;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    sum;
  logic [PW-1:0]       pad;

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    op_d    = op_q;
    acc_d   = acc_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    res_d   = res_q;
    // low half of the reciprocal first, then the high half
    mult_b  = (phase_q == PH_LO) ? RECIP_LO : RECIP_HI;
    prod    = PROD_W'(op_q) * PROD_W'(mult_b);
    sum     = SUM_W'(acc_q) + (SUM_W'(prod) << 16);
    pad     = (rem_q == '0) ? '0 : ALIGN_P - rem_q;
    if (start_i) begin
      phase_d = PH_LO;
      op_d    = operand_i;
    end else begin
      unique case (phase_q)
        PH_LO: begin
          acc_d   = prod;
          phase_d = PH_HI;
        end
        PH_HI: begin
          quot_d  = AW'(sum >> SHIFT);
          phase_d = PH_REM;
        end
        PH_REM: begin
          rem_d   = PW'(op_q - quot_q * ALIGN_A);
          phase_d = PH_ADD;
        end
        PH_ADD: begin
          res_d   = op_q + AW'(pad);
          done_d  = 1'b1;
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    acc_q  <= acc_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### rtl/fbpa_addr_unit.sv
// Block address unit: registered index times size, then add of the base.
module fbpa_addr_unit #(
  parameter int IDX_W = 8
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [IDX_W-1:0]             index_i,
  input  logic [fbpa_pkg::PSIZE_W-1:0] size_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]  base_i,
  output logic [fbpa_pkg::ADDR_W-1:0]  addr_o
);

  localparam int PROD_W = IDX_W + fbpa_pkg::PSIZE_W;

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(index_i) * PROD_W'(size_i);
    end
  end

  assign addr_o = base_i + fbpa_pkg::ADDR_W'(prod_q);

endmodule

### rtl/fbpa_checker.sv
// Port-level checks of the fixed block pool allocator, bound to the top level.
module fbpa_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [fbpa_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  // a held response keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("response changed while stalled");

  // one request at a time: busy right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // only a successful request may carry an index or address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != fbpa_pkg::ST_OK
      |-> m_axis_tdata[42:3] == '0)
    else $error("failed request carries a grant");

  // an underflow only happens on an empty pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == fbpa_pkg::ST_UNDERFLOW
      |-> m_axis_tdata[51:43] == '0)
    else $error("underflow with free blocks left");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
